FILE: design/mcc_pkg.sv
package mcc_pkg;

  localparam int MCC_MAX_CLASSES = 16;
  localparam int MCC_COUNT_BITS  = 16;
  localparam int CLASS_BITS      = 4;
  localparam int CFG_BITS        = 5;
  localparam int SAMPLE_BITS     = 16;
  localparam int Q_BITS          = 16;
  localparam int FRAC_SHIFT      = 30;
  localparam int MIN_CLASSES     = 2;

  localparam logic [CFG_BITS-1:0] CFG_RESET   = CFG_BITS'(2);
  localparam logic [Q_BITS-1:0]   MCC_POS_MAX = {1'b0, {(Q_BITS-1){1'b1}}};

  typedef logic [2:0] mul_op_t;

  localparam mul_op_t MOP_RC = 3'd0;
  localparam mul_op_t MOP_RR = 3'd1;
  localparam mul_op_t MOP_CC = 3'd2;
  localparam mul_op_t MOP_NN = 3'd3;
  localparam mul_op_t MOP_NT = 3'd4;
  localparam mul_op_t MOP_AB = 3'd5;
  localparam mul_op_t MOP_MM = 3'd6;

  typedef struct packed {
    logic [CLASS_BITS-1:0] actual_cls;
    logic [CLASS_BITS-1:0] guess_cls;
    logic                  last_sample;
  } mcc_in_t;

  typedef struct packed {
    logic signed [Q_BITS-1:0] mcc_value;
    logic [SAMPLE_BITS-1:0]   samples_counted;
    logic                     undefined_flag;
    logic                     dropped_flag;
    logic                     saturated_flag;
  } mcc_out_t;

  typedef struct packed {
    logic    accept;
    logic    sweep_init;
    logic    rd_issue;
    logic    acc;
    logic    row_end;
    logic    mul_start;
    mul_op_t mul_op;
    logic    form_ab;
    logic    form_mag;
    logic    sq_init;
    logic    sq_add;
    logic    sq_cmp;
    logic    load_out;
  } mcc_cmd_t;

  typedef struct packed {
    logic mul_done;
    logic j_last;
    logic i_last;
    logic ab_zero;
    logic sq_last;
  } mcc_status_t;

endpackage

FILE: design/mcc_mul.sv
module mcc_mul
  import mcc_pkg::*;
#(
  parameter int W = 2 * (MCC_COUNT_BITS + 8)
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  logic [W-1:0]   a,
  input  logic [W-1:0]   b,
  output logic           done,
  output logic [2*W-1:0] prod
);

  localparam int CNW = $clog2(W);

  logic [W-1:0]   a_r;
  logic [W-1:0]   hi_r;
  logic [W-1:0]   lo_r;
  logic [CNW-1:0] cnt_r;
  logic           busy_r;
  logic           done_r;
  logic [W:0]     sum;

  // shift-add, one multiplier bit per cycle
  assign sum = {1'b0, hi_r} + (lo_r[0] ? {1'b0, a_r} : '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && cnt_r == CNW'(W - 1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r   <= a;
      hi_r  <= '0;
      lo_r  <= b;
      cnt_r <= '0;
    end else if (busy_r) begin
      hi_r  <= sum[W:1];
      lo_r  <= {sum[0], lo_r[W-1:1]};
      cnt_r <= cnt_r + CNW'(1);
    end
  end

  assign done = done_r;
  assign prod = {hi_r, lo_r};

endmodule

FILE: design/mcc_dp.sv
module mcc_dp
  import mcc_pkg::*;
#(
  parameter int MAX_CLASSES = MCC_MAX_CLASSES,
  parameter int COUNT_BITS  = MCC_COUNT_BITS
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_wr_en,
  input  logic [CFG_BITS-1:0] cfg_wr_data,
  input  mcc_in_t             in_data,
  input  mcc_cmd_t            cmd,
  output mcc_status_t         status,
  output mcc_out_t            out_data
);

  localparam int LG    = $clog2(MAX_CLASSES);
  localparam int KW    = $clog2(MAX_CLASSES + 1);
  localparam int DEPTH = MAX_CLASSES * MAX_CLASSES;
  localparam int AW    = $clog2(DEPTH);
  localparam int RW    = COUNT_BITS + LG;
  localparam int NW    = COUNT_BITS + 2 * LG;
  localparam int PW    = 2 * NW;
  localparam int SW    = 2 * PW + 33;
  localparam int QB    = $clog2(Q_BITS);

  localparam logic [COUNT_BITS-1:0]  CMAX = '1;
  localparam logic [SAMPLE_BITS-1:0] SMAX = '1;

  // configuration and effective class count
  logic [CFG_BITS-1:0] cfg_r;
  logic [KW-1:0]       k_eff;
  logic [31:0]         k_last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_RESET;
    end else if (cfg_wr_en) begin
      cfg_r <= cfg_wr_data;
    end
  end

  always_comb begin
    if (32'(cfg_r) < 32'(MIN_CLASSES)) begin
      k_eff = KW'(MIN_CLASSES);
    end else if (32'(cfg_r) > 32'(MAX_CLASSES)) begin
      k_eff = KW'(MAX_CLASSES);
    end else begin
      k_eff = KW'(cfg_r);
    end
  end

  assign k_last = 32'(k_eff) - 32'd1;

  // table memory with valid bits
  logic [COUNT_BITS-1:0] mem [DEPTH];
  logic [DEPTH-1:0]      vbits_r;
  logic [COUNT_BITS-1:0] rd0_r;
  logic [COUNT_BITS-1:0] rd1_r;
  logic                  vb0_r;
  logic                  vb1_r;

  logic [LG-1:0] i_r;
  logic [LG-1:0] j_r;
  logic [AW-1:0] in_addr;
  logic [AW-1:0] addr_ij;
  logic [AW-1:0] addr_ji;
  logic [AW-1:0] rd_addr0;
  logic          in_ok;

  assign in_ok = (32'(in_data.actual_cls) < 32'(k_eff)) &&
                 (32'(in_data.guess_cls) < 32'(k_eff));
  assign in_addr = AW'(32'(in_data.actual_cls) * 32'(MAX_CLASSES) +
                       32'(in_data.guess_cls));
  assign addr_ij = AW'(32'(i_r) * 32'(MAX_CLASSES) + 32'(j_r));
  assign addr_ji = AW'(32'(j_r) * 32'(MAX_CLASSES) + 32'(i_r));
  assign rd_addr0 = cmd.accept ? in_addr : addr_ij;

  // second counting stage
  logic                   s2_valid_r;
  logic                   s2_ok_r;
  logic [AW-1:0]          s2_addr_r;
  logic                   hold_valid_r;
  logic [AW-1:0]          hold_addr_r;
  logic [COUNT_BITS-1:0]  hold_val_r;
  logic [COUNT_BITS-1:0]  cnt_old;
  logic [COUNT_BITS-1:0]  cnt_new;
  logic                   wr_en;
  logic [SAMPLE_BITS-1:0] total_r;
  logic [SAMPLE_BITS-1:0] total_new;
  logic                   dropped_r;
  logic                   sat_r;

  // forward the entry written in the previous cycle, the read did not see it
  always_comb begin
    if (hold_valid_r && hold_addr_r == s2_addr_r) begin
      cnt_old = hold_val_r;
    end else if (vb0_r) begin
      cnt_old = rd0_r;
    end else begin
      cnt_old = '0;
    end
  end

  assign cnt_new   = (cnt_old == CMAX) ? cnt_old : cnt_old + COUNT_BITS'(1);
  assign total_new = (total_r == SMAX) ? total_r : total_r + SAMPLE_BITS'(1);
  assign wr_en     = s2_valid_r && s2_ok_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[s2_addr_r] <= cnt_new;
    end
    rd0_r <= mem[rd_addr0];
    rd1_r <= mem[addr_ji];
    vb0_r <= vbits_r[rd_addr0];
    vb1_r <= vbits_r[addr_ji];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vbits_r      <= '0;
      s2_valid_r   <= 1'b0;
      hold_valid_r <= 1'b0;
      total_r      <= '0;
      dropped_r    <= 1'b0;
      sat_r        <= 1'b0;
    end else if (cmd.load_out) begin
      vbits_r      <= '0;
      s2_valid_r   <= 1'b0;
      hold_valid_r <= 1'b0;
      total_r      <= '0;
      dropped_r    <= 1'b0;
      sat_r        <= 1'b0;
    end else begin
      s2_valid_r   <= cmd.accept;
      hold_valid_r <= wr_en;
      if (wr_en) begin
        vbits_r[s2_addr_r] <= 1'b1;
        total_r            <= total_new;
        if (cnt_new == CMAX || total_new == SMAX) begin
          sat_r <= 1'b1;
        end
      end
      if (s2_valid_r && !s2_ok_r) begin
        dropped_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      s2_ok_r   <= in_ok;
      s2_addr_r <= in_addr;
    end
    hold_addr_r <= s2_addr_r;
    hold_val_r  <= cnt_new;
  end

  // sweep over the table
  logic [COUNT_BITS-1:0] val0;
  logic [COUNT_BITS-1:0] val1;
  logic [RW-1:0]         r_r;
  logic [RW-1:0]         c_r;
  logic [RW-1:0]         tr_r;
  logic [NW-1:0]         n_r;
  logic [PW-1:0]         dot_r;
  logic [PW-1:0]         sr2_r;
  logic [PW-1:0]         sc2_r;
  logic [PW-1:0]         nn_r;
  logic [PW-1:0]         p_r;
  logic [PW-1:0]         a_r;
  logic [PW-1:0]         b_r;
  logic [PW-1:0]         mag_r;
  logic                  neg_r;
  logic [2*PW-1:0]       ab_r;
  logic [2*PW-1:0]       mm_r;

  assign val0 = vb0_r ? rd0_r : '0;
  assign val1 = vb1_r ? rd1_r : '0;

  // shared multiplier
  logic [PW-1:0]   mul_a;
  logic [PW-1:0]   mul_b;
  logic            mul_done;
  logic [2*PW-1:0] prod;

  always_comb begin
    case (cmd.mul_op)
      MOP_RC: begin
        mul_a = PW'(r_r);
        mul_b = PW'(c_r);
      end
      MOP_RR: begin
        mul_a = PW'(r_r);
        mul_b = PW'(r_r);
      end
      MOP_CC: begin
        mul_a = PW'(c_r);
        mul_b = PW'(c_r);
      end
      MOP_NN: begin
        mul_a = PW'(n_r);
        mul_b = PW'(n_r);
      end
      MOP_NT: begin
        mul_a = PW'(n_r);
        mul_b = PW'(tr_r);
      end
      MOP_AB: begin
        mul_a = a_r;
        mul_b = b_r;
      end
      MOP_MM: begin
        mul_a = mag_r;
        mul_b = mag_r;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  mcc_mul #(
    .W (PW)
  ) u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .prod  (prod)
  );

  always_ff @(posedge clk) begin
    if (cmd.sweep_init) begin
      i_r   <= '0;
      j_r   <= '0;
      r_r   <= '0;
      c_r   <= '0;
      tr_r  <= '0;
      n_r   <= '0;
      dot_r <= '0;
      sr2_r <= '0;
      sc2_r <= '0;
    end else if (cmd.acc) begin
      r_r <= r_r + RW'(val0);
      c_r <= c_r + RW'(val1);
      if (i_r == j_r) begin
        tr_r <= tr_r + RW'(val0);
      end
      if (!status.j_last) begin
        j_r <= j_r + LG'(1);
      end
    end else if (cmd.row_end) begin
      n_r <= n_r + NW'(r_r);
      r_r <= '0;
      c_r <= '0;
      j_r <= '0;
      if (!status.i_last) begin
        i_r <= i_r + LG'(1);
      end
    end else if (mul_done) begin
      case (cmd.mul_op)
        MOP_RC:  dot_r <= dot_r + prod[PW-1:0];
        MOP_RR:  sr2_r <= sr2_r + prod[PW-1:0];
        MOP_CC:  sc2_r <= sc2_r + prod[PW-1:0];
        MOP_NN:  nn_r  <= prod[PW-1:0];
        MOP_NT:  p_r   <= prod[PW-1:0];
        MOP_AB:  ab_r  <= prod;
        MOP_MM:  mm_r  <= prod;
        default: ;
      endcase
    end else if (cmd.form_ab) begin
      a_r <= nn_r - sr2_r;
      b_r <= nn_r - sc2_r;
    end else if (cmd.form_mag) begin
      neg_r <= p_r < dot_r;
      mag_r <= (p_r < dot_r) ? dot_r - p_r : p_r - dot_r;
    end
  end

  // root search: largest q with q^2 * ab <= mm * 2^30, one bit per add and compare step
  // s = q^2 * ab, d = q * ab << (bit + 1), x = ab << (2 * bit)
  logic [SW-1:0]     s_r;
  logic [SW-1:0]     d_r;
  logic [SW-1:0]     x_r;
  logic [SW-1:0]     cand_r;
  logic [SW-1:0]     rhs;
  logic [Q_BITS-1:0] q_r;
  logic [QB-1:0]     bit_r;

  assign rhs = SW'(mm_r) << FRAC_SHIFT;

  always_ff @(posedge clk) begin
    if (cmd.sq_init) begin
      s_r   <= '0;
      d_r   <= '0;
      x_r   <= SW'(ab_r) << (2 * (Q_BITS - 1));
      q_r   <= '0;
      bit_r <= QB'(Q_BITS - 1);
    end else if (cmd.sq_add) begin
      cand_r <= s_r + d_r + x_r;
    end else if (cmd.sq_cmp) begin
      if (cand_r <= rhs) begin
        s_r <= cand_r;
        d_r <= (d_r + (x_r << 1)) >> 1;
        q_r <= q_r | (Q_BITS'(1) << bit_r);
      end else begin
        d_r <= d_r >> 1;
      end
      x_r   <= x_r >> 2;
      bit_r <= bit_r - QB'(1);
    end
  end

  // result
  logic [Q_BITS-1:0] mcc_bits;

  always_comb begin
    if (status.ab_zero) begin
      mcc_bits = '0;
    end else if (neg_r) begin
      mcc_bits = Q_BITS'(0) - q_r;
    end else if (q_r > MCC_POS_MAX) begin
      mcc_bits = MCC_POS_MAX;
    end else begin
      mcc_bits = q_r;
    end
  end

  mcc_out_t out_r;

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_r.mcc_value       <= signed'(mcc_bits);
      out_r.samples_counted <= total_r;
      out_r.undefined_flag  <= status.ab_zero;
      out_r.dropped_flag    <= dropped_r;
      out_r.saturated_flag  <= sat_r;
    end
  end

  assign out_data = out_r;

  assign status.mul_done = mul_done;
  assign status.j_last   = (32'(j_r) == k_last);
  assign status.i_last   = (32'(i_r) == k_last);
  assign status.ab_zero  = (a_r == '0) || (b_r == '0);
  assign status.sq_last  = (bit_r == '0);

endmodule

FILE: design/mcc_ctrl.sv
module mcc_ctrl
  import mcc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_last,
  output logic        in_stall,
  output logic        out_valid,
  input  logic        out_stall,
  input  mcc_status_t status,
  output mcc_cmd_t    cmd
);

  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_DRAIN  = 4'd1;
  localparam logic [3:0] ST_RD     = 4'd2;
  localparam logic [3:0] ST_ACC    = 4'd3;
  localparam logic [3:0] ST_MSTART = 4'd4;
  localparam logic [3:0] ST_MWAIT  = 4'd5;
  localparam logic [3:0] ST_ROWEND = 4'd6;
  localparam logic [3:0] ST_FORMAB = 4'd7;
  localparam logic [3:0] ST_CHK    = 4'd8;
  localparam logic [3:0] ST_MAG    = 4'd9;
  localparam logic [3:0] ST_SQINIT = 4'd10;
  localparam logic [3:0] ST_SQA    = 4'd11;
  localparam logic [3:0] ST_SQC    = 4'd12;
  localparam logic [3:0] ST_OUT    = 4'd13;

  logic [3:0] state_r;
  logic [3:0] state_nxt;
  mul_op_t    op_r;
  mul_op_t    op_nxt;
  logic       out_valid_r;
  logic       out_free;
  logic       accept;

  assign in_stall = (state_r != ST_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt      = state_r;
    op_nxt         = op_r;
    cmd            = '0;
    cmd.mul_op     = op_r;
    cmd.accept     = accept;
    case (state_r)
      ST_IDLE: begin
        if (accept && in_last) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        cmd.sweep_init = 1'b1;
        state_nxt      = ST_RD;
      end
      ST_RD: begin
        cmd.rd_issue = 1'b1;
        state_nxt    = ST_ACC;
      end
      ST_ACC: begin
        cmd.acc = 1'b1;
        if (status.j_last) begin
          op_nxt    = MOP_RC;
          state_nxt = ST_MSTART;
        end else begin
          state_nxt = ST_RD;
        end
      end
      ST_MSTART: begin
        cmd.mul_start = 1'b1;
        state_nxt     = ST_MWAIT;
      end
      ST_MWAIT: begin
        if (status.mul_done) begin
          case (op_r)
            MOP_RC: begin
              op_nxt    = MOP_RR;
              state_nxt = ST_MSTART;
            end
            MOP_RR: begin
              op_nxt    = MOP_CC;
              state_nxt = ST_MSTART;
            end
            MOP_CC:  state_nxt = ST_ROWEND;
            MOP_NN:  state_nxt = ST_FORMAB;
            MOP_NT:  state_nxt = ST_MAG;
            MOP_AB: begin
              op_nxt    = MOP_MM;
              state_nxt = ST_MSTART;
            end
            MOP_MM:  state_nxt = ST_SQINIT;
            default: state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_ROWEND: begin
        cmd.row_end = 1'b1;
        if (status.i_last) begin
          op_nxt    = MOP_NN;
          state_nxt = ST_MSTART;
        end else begin
          state_nxt = ST_RD;
        end
      end
      ST_FORMAB: begin
        cmd.form_ab = 1'b1;
        state_nxt   = ST_CHK;
      end
      ST_CHK: begin
        if (status.ab_zero) begin
          state_nxt = ST_OUT;
        end else begin
          op_nxt    = MOP_NT;
          state_nxt = ST_MSTART;
        end
      end
      ST_MAG: begin
        cmd.form_mag = 1'b1;
        op_nxt       = MOP_AB;
        state_nxt    = ST_MSTART;
      end
      ST_SQINIT: begin
        cmd.sq_init = 1'b1;
        state_nxt   = ST_SQA;
      end
      ST_SQA: begin
        cmd.sq_add = 1'b1;
        state_nxt  = ST_SQC;
      end
      ST_SQC: begin
        cmd.sq_cmp = 1'b1;
        state_nxt  = status.sq_last ? ST_OUT : ST_SQA;
      end
      ST_OUT: begin
        if (out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      op_r        <= MOP_RC;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      op_r    <= op_nxt;
      if (cmd.load_out) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid = out_valid_r;

endmodule

FILE: design/multiclass_confusion_mcc.sv
// Multiclass Matthews correlation over a stream of (true, predicted) class pairs.
// Input channel in_valid/in_stall/in_data: one transaction per sample. While
// counting, a sample is taken every cycle (two-stage read-modify-write of the
// confusion table with forwarding of the entry written in the previous cycle).
// A transaction with last_sample set closes the set: the block stalls the
// input, sweeps the K-by-K table entry by entry, runs the products through one
// shift-add multiplier of PW = 2*(COUNT_BITS + 2*clog2(MAX_CLASSES)) bits (3K + 4
// products, or 3K + 1 when the denominator is zero) and, with a nonzero
// denominator, a bit-serial root search; with defaults PW is 48.
// The output channel out_valid/out_stall/out_data carries one result transaction
// per set; it sits in an output register, so new samples are taken while it
// waits. If a new set finishes while the old result is still stalled, the
// block holds the new result until the register frees.
// cfg_wr_en/cfg_wr_data sets the class count; write it only while idle.
// Synchronous reset clears the table, counters, flags and sets the count to 2.
module multiclass_confusion_mcc
  import mcc_pkg::*;
#(
  parameter int MAX_CLASSES = MCC_MAX_CLASSES,
  parameter int COUNT_BITS  = MCC_COUNT_BITS
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_wr_en,
  input  logic [CFG_BITS-1:0] cfg_wr_data,
  input  logic                in_valid,
  output logic                in_stall,
  input  mcc_in_t             in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output mcc_out_t            out_data
);

  mcc_cmd_t    cmd;
  mcc_status_t status;

  mcc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_last   (in_data.last_sample),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  mcc_dp #(
    .MAX_CLASSES (MAX_CLASSES),
    .COUNT_BITS  (COUNT_BITS)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_data     (in_data),
    .cmd         (cmd),
    .status      (status),
    .out_data    (out_data)
  );

endmodule

FILE: verif/tb.sv
module tb;
  import mcc_pkg::*;

  localparam int LIMIT_CYCLES = 20_000_000;
  localparam int RUN_REPEAT   = 4;

  typedef logic [255:0] wide_t;

  typedef struct {
    int       tc;
    int       pc;
    bit       last;
    int       rep;
    bit       typed;
    mcc_out_t res;
  } dir_row_t;

  logic            clk = 1'b0;
  logic            rst_n = 1'b0;
  logic            cfg_wr_en = 1'b0;
  logic [CFG_BITS-1:0] cfg_wr_data = '0;
  logic            in_valid = 1'b0;
  logic            in_stall;
  mcc_in_t         in_data = '0;
  logic            out_valid;
  logic            out_stall = 1'b0;
  mcc_out_t        out_data;

  // typed expectation that rides along with the current input transaction
  bit              cur_typed = 1'b0;
  mcc_out_t        cur_res = '0;

  int unsigned     conf_tbl[MCC_MAX_CLASSES*MCC_MAX_CLASSES];
  int unsigned     sample_cnt;
  bit              drop_seen, sat_seen;
  logic [CFG_BITS-1:0] class_cfg;

  mcc_out_t        mcc_q[$];
  dir_row_t        dir_tab[$];
  int              errors = 0;
  int              cycles = 0;
  int              n_in = 0, n_out = 0;
  int              n_undef = 0, n_drop = 0, n_sat = 0, n_neg = 0;
  int              burst_left = 0;
  int              hold_req = 0;
  int              stall_mode = 0;

  multiclass_confusion_mcc DUT (
    .clk(clk), .rst_n(rst_n),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  always #6 clk = ~clk;

  function automatic int eff_k();
    int k;
    k = int'(class_cfg);
    if (k < MIN_CLASSES) k = MIN_CLASSES;
    if (k > MCC_MAX_CLASSES) k = MCC_MAX_CLASSES;
    return k;
  endfunction

  function automatic void clear_counts();
    foreach (conf_tbl[i]) conf_tbl[i] = 0;
    sample_cnt = 0;
    drop_seen = 1'b0;
    sat_seen = 1'b0;
  endfunction

  // exact-integer correlation over the k-by-k table
  function automatic mcc_out_t correlation(int k);
    mcc_out_t    o;
    wide_t       dot, sr2, sc2, nn, a, b, p, mag, ab, rhs, t;
    longint      n, tr, r, c;
    int unsigned lo, hi, mid;
    bit          neg;
    dot = '0; sr2 = '0; sc2 = '0; n = 0; tr = 0;
    for (int i = 0; i < k; i++) begin
      r = 0; c = 0;
      tr += conf_tbl[i*MCC_MAX_CLASSES+i];
      for (int j = 0; j < k; j++) begin
        r += conf_tbl[i*MCC_MAX_CLASSES+j];
        c += conf_tbl[j*MCC_MAX_CLASSES+i];
      end
      n += r;
      dot += wide_t'(r) * wide_t'(c);
      sr2 += wide_t'(r) * wide_t'(r);
      sc2 += wide_t'(c) * wide_t'(c);
    end
    nn = wide_t'(n) * wide_t'(n);
    a = nn - sr2;
    b = nn - sc2;
    o = '0;
    o.samples_counted = sample_cnt[15:0];
    o.dropped_flag = drop_seen;
    o.saturated_flag = sat_seen;
    if (a == 0 || b == 0) begin
      o.undefined_flag = 1'b1;
      o.mcc_value = '0;
      return o;
    end
    p = wide_t'(n) * wide_t'(tr);
    neg = p < dot;
    mag = neg ? dot - p : p - dot;
    ab = a * b;
    rhs = (mag * mag) << FRAC_SHIFT;
    lo = 0; hi = 32768;
    while (lo < hi) begin
      mid = (lo + hi + 1) / 2;
      t = wide_t'(mid) * wide_t'(mid) * ab;
      if (t <= rhs) lo = mid;
      else hi = mid - 1;
    end
    if (!neg) o.mcc_value = (lo > 32767) ? MCC_POS_MAX : lo[15:0];
    else o.mcc_value = 16'(32'h10000 - lo);
    return o;
  endfunction

  // counts one sample; returns 1 with the result when the set closes
  function automatic bit count_sample(mcc_in_t d, output mcc_out_t res);
    int k, idx;
    k = eff_k();
    res = '0;
    if (int'(d.actual_cls) >= k || int'(d.guess_cls) >= k) begin
      drop_seen = 1'b1;
    end else begin
      idx = int'(d.actual_cls) * MCC_MAX_CLASSES + int'(d.guess_cls);
      if (conf_tbl[idx] < 65535) conf_tbl[idx]++;
      if (conf_tbl[idx] == 65535) sat_seen = 1'b1;
      if (sample_cnt < 65535) sample_cnt++;
      if (sample_cnt == 65535) sat_seen = 1'b1;
    end
    if (!d.last_sample) return 1'b0;
    res = correlation(k);
    clear_counts();
    return 1'b1;
  endfunction

  always @(posedge clk) begin
    mcc_out_t r, e;
    cycles <= cycles + 1;
    if (cycles >= LIMIT_CYCLES) begin
      $display("timeout after %0d cycles", cycles);
      $display("simulation failed");
      $finish;
    end
    if (rst_n && in_valid && !in_stall) begin
      n_in++;
      if (count_sample(in_data, r)) mcc_q.insert(mcc_q.size(), cur_typed ? cur_res : r);
    end
    if (rst_n && out_valid && !out_stall) begin
      n_out++;
      if (mcc_q.size() == 0) begin
        $error("result transaction with nothing expected");
        errors++;
      end else begin
        e = mcc_q.pop_front();
        if (out_data.mcc_value !== e.mcc_value) begin
          $error("mcc_value: expected %0d, got %0d", e.mcc_value, out_data.mcc_value);
          errors++;
        end
        if (out_data.samples_counted !== e.samples_counted) begin
          $error("samples_counted: expected %0d, got %0d",
                 e.samples_counted, out_data.samples_counted);
          errors++;
        end
        if (out_data.undefined_flag !== e.undefined_flag) begin
          $error("undefined_flag: expected %0b, got %0b",
                 e.undefined_flag, out_data.undefined_flag);
          errors++;
        end
        if (out_data.dropped_flag !== e.dropped_flag) begin
          $error("dropped_flag: expected %0b, got %0b", e.dropped_flag, out_data.dropped_flag);
          errors++;
        end
        if (out_data.saturated_flag !== e.saturated_flag) begin
          $error("saturated_flag: expected %0b, got %0b",
                 e.saturated_flag, out_data.saturated_flag);
          errors++;
        end
        if (out_data.undefined_flag) n_undef++;
        if (out_data.dropped_flag) n_drop++;
        if (out_data.saturated_flag) n_sat++;
        if (out_data.mcc_value < 0) n_neg++;
      end
    end
  end

  // receiver: random stall pattern from four modes, long hold on request
  always @(negedge clk) begin
    if (cycles % 200 == 0) stall_mode = $urandom_range(0, 3);
    if (hold_req > 0) begin
      out_stall <= 1'b1;
      hold_req = hold_req - 1;
    end else begin
      case (stall_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 3) == 0);
        2: out_stall <= ($urandom_range(0, 9) < 7);
        default: out_stall <= ($urandom_range(0, 1) == 0);
      endcase
    end
  end

  task automatic send(int tc, int pc, bit last, bit typed, mcc_out_t res);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
    end else begin
      gap = 0;
    end
    burst_left--;
    @(negedge clk);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    in_data = '{actual_cls: 4'(tc), guess_cls: 4'(pc), last_sample: last};
    cur_typed = typed;
    cur_res = res;
    do @(posedge clk); while (in_stall);
  endtask

  // sender pause until every expected result is back
  task automatic drain();
    @(negedge clk);
    in_valid = 1'b0;
    cur_typed = 1'b0;
    while (mcc_q.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
  endtask

  task automatic write_classes(logic [CFG_BITS-1:0] v);
    @(negedge clk);
    cfg_wr_en = 1'b1;
    cfg_wr_data = v;
    @(negedge clk);
    cfg_wr_en = 1'b0;
    class_cfg = v;
  endtask

  function automatic void add_row(int tc, int pc, bit last, int rep, bit typed,
                                  int v, int s, bit u, bit d, bit sat);
    dir_row_t row;
    row.tc = tc; row.pc = pc; row.last = last; row.rep = rep; row.typed = typed;
    row.res = '{mcc_value: 16'(v), samples_counted: 16'(s), undefined_flag: u,
                dropped_flag: d, saturated_flag: sat};
    dir_tab.insert(dir_tab.size(), row);
  endfunction

  initial begin
    int          k, set_len, style, tc, pc, sent;
    int          k_list[8];
    mcc_out_t    none;
    none = '0;
    k_list = '{0, 16, 31, 1, 3, 9, 5, 16};
    class_cfg = CFG_RESET;
    clear_counts();
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed, two classes after reset
    add_row(3, 0, 1, 1, 1, 0, 0, 1, 1, 0);          // empty set, only a dropped sample
    add_row(0, 0, 1, 1, 1, 0, 1, 1, 0, 0);          // one sample: zero denominator
    add_row(0, 0, 0, 1, 0, 0, 0, 0, 0, 0);
    add_row(1, 1, 1, 1, 1, 32767, 2, 0, 0, 0);      // perfect: clamped to max
    add_row(0, 1, 0, 1, 0, 0, 0, 0, 0, 0);
    add_row(1, 0, 1, 1, 1, -32768, 2, 0, 0, 0);     // fully inverted
    add_row(0, 0, 0, 3, 0, 0, 0, 0, 0, 0);
    add_row(0, 1, 0, 1, 0, 0, 0, 0, 0, 0);
    add_row(15, 15, 0, 1, 0, 0, 0, 0, 0, 0);
    add_row(1, 15, 0, 1, 0, 0, 0, 0, 0, 0);
    add_row(1, 1, 0, 2, 0, 0, 0, 0, 0, 0);
    add_row(1, 0, 1, 1, 0, 0, 0, 0, 0, 0);
    add_row(1, 1, 0, RUN_REPEAT, 0, 0, 0, 0, 0, 0); // same entry RUN_REPEAT times, back to back unless a burst ends
    add_row(0, 0, 1, 1, 0, 0, 0, 0, 0, 0);
    add_row(1, 0, 0, 1, 0, 0, 0, 0, 0, 0);
    add_row(0, 1, 1, 1, 0, 0, 0, 0, 0, 0);
    foreach (dir_tab[i])
      for (int j = 0; j < dir_tab[i].rep; j++)
        send(dir_tab[i].tc, dir_tab[i].pc, dir_tab[i].last && j == dir_tab[i].rep - 1,
             dir_tab[i].typed, dir_tab[i].res);
    drain();

    // random sets across class-count settings
    for (int ph = 0; ph < 8; ph++) begin
      write_classes(CFG_BITS'(k_list[ph]));
      k = eff_k();
      if (ph == 4) hold_req = 4000;
      sent = 0;
      while (sent < 65) begin
        set_len = ($urandom_range(0, 15) == 0) ? $urandom_range(20, 60)
                                                : $urandom_range(1, 10);
        style = $urandom_range(0, 3);
        for (int s = 0; s < set_len; s++) begin
          tc = $urandom_range(0, k - 1);
          case (style)
            0: pc = ($urandom_range(0, 9) < 7) ? tc : $urandom_range(0, k - 1);
            1: pc = k - 1 - tc;
            default: pc = $urandom_range(0, k - 1);
          endcase
          if ($urandom_range(0, 11) == 0) begin
            tc = $urandom_range(0, 15);
            pc = $urandom_range(0, 15);
          end
          send(tc, pc, s == set_len - 1, 1'b0, none);
          sent++;
        end
      end
      drain();
    end
    write_classes(CFG_RESET);

    repeat (100) @(posedge clk);
    $display("%0d samples in, %0d results checked over eight class-count settings",
             n_in, n_out);
    $display("undefined %0d, dropped %0d, saturated %0d, negative %0d",
             n_undef, n_drop, n_sat, n_neg);
    if (errors == 0 && mcc_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

FILE: filelist.f
design/mcc_pkg.sv
design/mcc_mul.sv
design/mcc_dp.sv
design/mcc_ctrl.sv
design/multiclass_confusion_mcc.sv
verif/tb.sv
